// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the slot pool allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/fspa_pkg.sv =====
// ----------------------------------------------------------------------------
// fspa_pkg
// Shared types, codes and constants of the slot pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fspa_pkg;

	localparam int MAX_POOLS_DEF      = 8;
	localparam int SLOTS_PER_POOL_DEF = 1024;

	localparam int SLOT_BYTES_W   = 17;
	localparam int POOL_SLOTS_W   = 11;
	localparam int REQ_W          = 17;
	localparam int POOL_FW        = 3;
	localparam int SLOT_FW        = 10;
	localparam int STATUS_W       = 3;
	localparam int OPEN_FW        = 4;
	localparam int SLOT_BYTES_RST = 64;
	localparam int POOL_SLOTS_RST = 1024;

	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 24;

	localparam logic MODE_FREE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOC     = 3'd0,
		ST_FREED     = 3'd1,
		ST_NO_POOL   = 3'd2,
		ST_UNKNOWN   = 3'd3,
		ST_TOO_LARGE = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		REG_SLOT_BYTES = 1'b0,
		REG_POOL_SLOTS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_LINK
	} state_t;

	typedef struct packed {
		logic    capture;
		logic    walk;
		logic    link_rd;
		logic    free_wr;
		logic    bump_wr;
		logic    pop_wr;
		logic    open_wr;
		logic    load_out;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic mode_free;
		logic oversize;
		logic bad_free;
		logic nonempty;
		logic bump_ok;
		logic ptr_zero;
		logic can_open;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ===== sv/fspa_ram.sv =====
// ----------------------------------------------------------------------------
// fspa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fspa_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 2,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/fspa_regs.sv =====
// ----------------------------------------------------------------------------
// fspa_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module fspa_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [fspa_pkg::APB_AW-1:0]       paddr,
	input  wire logic [fspa_pkg::APB_DW-1:0]       pwdata,
	output      logic [fspa_pkg::APB_DW-1:0]       prdata,
	output      logic                              pready,
	output      logic [fspa_pkg::SLOT_BYTES_W-1:0] slot_bytes,
	output      logic [fspa_pkg::POOL_SLOTS_W-1:0] pool_slots
);

	logic               wr_fire;
	fspa_pkg::reg_idx_t reg_sel;

	assign pready  = 1'b1;
	assign wr_fire = psel && penable && pwrite && pready;
	assign reg_sel = fspa_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes <= fspa_pkg::SLOT_BYTES_W'(fspa_pkg::SLOT_BYTES_RST);
			pool_slots <= fspa_pkg::POOL_SLOTS_W'(fspa_pkg::POOL_SLOTS_RST);
		end else if (wr_fire) begin
			unique case (reg_sel)
				fspa_pkg::REG_SLOT_BYTES: slot_bytes <= pwdata[fspa_pkg::SLOT_BYTES_W-1:0];
				fspa_pkg::REG_POOL_SLOTS: pool_slots <= pwdata[fspa_pkg::POOL_SLOTS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			fspa_pkg::REG_SLOT_BYTES: prdata = fspa_pkg::APB_DW'(slot_bytes);
			fspa_pkg::REG_POOL_SLOTS: prdata = fspa_pkg::APB_DW'(pool_slots);
			default:                  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/fspa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fspa_ctrl
// Request sequencer: accepts a request, walks the pools and commits a result.
// ----------------------------------------------------------------------------
`default_nettype none

module fspa_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output      logic            in_ready,
	input  wire fspa_pkg::stat_t stat,
	output      fspa_pkg::cmd_t  cmd
);

	fspa_pkg::state_t state_q;
	fspa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fspa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fspa_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = fspa_pkg::S_CHECK;
				end
			end
			fspa_pkg::S_CHECK: begin
				if (!stat.mode_free && !stat.oversize && stat.nonempty) begin
					state_d = fspa_pkg::S_LINK;
				end else if (!stat.mode_free && !stat.oversize && !stat.bump_ok &&
						!stat.ptr_zero) begin
					state_d = fspa_pkg::S_CHECK;
				end else if (stat.out_free) begin
					state_d = fspa_pkg::S_IDLE;
				end
			end
			fspa_pkg::S_LINK: begin
				if (stat.out_free) begin
					state_d = fspa_pkg::S_IDLE;
				end
			end
			default: state_d = fspa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.code = fspa_pkg::ST_ALLOC;
		in_ready = 1'b0;
		unique case (state_q)
			fspa_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			fspa_pkg::S_CHECK: begin
				if (stat.mode_free) begin
					if (stat.out_free) begin
						cmd.load_out = 1'b1;
						if (stat.bad_free) begin
							cmd.code = fspa_pkg::ST_UNKNOWN;
						end else begin
							cmd.free_wr = 1'b1;
							cmd.code    = fspa_pkg::ST_FREED;
						end
					end
				end else if (stat.oversize) begin
					cmd.load_out = stat.out_free;
					cmd.code     = fspa_pkg::ST_TOO_LARGE;
				end else if (stat.nonempty) begin
					cmd.link_rd = 1'b1;
				end else if (stat.bump_ok) begin
					cmd.load_out = stat.out_free;
					cmd.bump_wr  = stat.out_free;
				end else if (!stat.ptr_zero) begin
					cmd.walk = 1'b1;
				end else if (stat.out_free) begin
					cmd.load_out = 1'b1;
					if (stat.can_open) begin
						cmd.open_wr = 1'b1;
					end else begin
						cmd.code = fspa_pkg::ST_NO_POOL;
					end
				end
			end
			fspa_pkg::S_LINK: begin
				cmd.load_out = stat.out_free;
				cmd.pop_wr   = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/fspa_dp.sv =====
// ----------------------------------------------------------------------------
// fspa_dp
// Allocator datapath: request registers, pool state, link store, result.
// ----------------------------------------------------------------------------
`default_nettype none

module fspa_dp #(
	parameter int MAX_POOLS      = fspa_pkg::MAX_POOLS_DEF,
	parameter int SLOTS_PER_POOL = fspa_pkg::SLOTS_PER_POOL_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire fspa_pkg::cmd_t                    cmd,
	output      fspa_pkg::stat_t                   stat,
	input  wire logic                              mode,
	input  wire logic [fspa_pkg::REQ_W-1:0]        request_bytes,
	input  wire logic [fspa_pkg::POOL_FW-1:0]      free_pool,
	input  wire logic [fspa_pkg::SLOT_FW-1:0]      free_slot,
	input  wire logic [fspa_pkg::SLOT_BYTES_W-1:0] slot_bytes,
	input  wire logic [fspa_pkg::POOL_SLOTS_W-1:0] pool_slots,
	input  wire logic                              out_ready,
	output      logic                              out_valid,
	output      logic [fspa_pkg::POOL_FW-1:0]      grant_pool,
	output      logic [fspa_pkg::SLOT_FW-1:0]      grant_slot,
	output      logic [fspa_pkg::STATUS_W-1:0]     status,
	output      logic [fspa_pkg::OPEN_FW-1:0]      pools_open
);

	localparam int PW         = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
	localparam int SW         = $clog2(SLOTS_PER_POOL);
	localparam int BW         = SW + 1;
	localparam int CW         = $clog2(MAX_POOLS + 1);
	localparam int PWORD_W    = BW + SW;
	localparam int LINK_W     = SW + 1;
	localparam int LINK_DEPTH = MAX_POOLS * (2 ** SW);
	localparam int LINK_AW    = $clog2(LINK_DEPTH);

	logic                          mode_q;
	logic [fspa_pkg::REQ_W-1:0]    req_q;
	logic [fspa_pkg::POOL_FW-1:0]  fpool_q;
	logic [fspa_pkg::SLOT_FW-1:0]  fslot_q;
	logic [PW-1:0]                 ptr_q;
	logic [PW-1:0]                 ptr_d;
	logic [CW-1:0]                 open_q;
	logic [CW-1:0]                 open_d;
	logic [MAX_POOLS-1:0]          empty_q;
	logic [MAX_POOLS-1:0]          bval_q;
	logic [BW-1:0]                 lim;
	logic [SW-1:0]                 fslot_idx;
	logic [PW-1:0]                 open_idx;

	logic                          pool_wr_en;
	logic [PW-1:0]                 pool_wr_addr;
	logic [PWORD_W-1:0]            pool_wr_data;
	logic [PWORD_W-1:0]            pool_rd_data;
	logic [SW-1:0]                 head_rd;
	logic [BW-1:0]                 bump_cur;

	logic [LINK_W-1:0]             link_wr_data;
	logic [LINK_W-1:0]             link_rd_data;
	logic [LINK_AW-1:0]            link_wr_addr;
	logic [LINK_AW-1:0]            link_rd_addr;
	logic                          link_end;
	logic [SW-1:0]                 link_idx;

	logic [fspa_pkg::POOL_FW-1:0]  gp_d;
	logic [fspa_pkg::SLOT_FW-1:0]  gs_d;

	assign fslot_idx = SW'(fslot_q);
	assign open_idx  = PW'(open_q);
	assign head_rd   = pool_rd_data[SW-1:0];
	assign bump_cur  = bval_q[ptr_q] ? pool_rd_data[PWORD_W-1:SW] : '0;
	assign link_end  = link_rd_data[LINK_W-1];
	assign link_idx  = link_rd_data[SW-1:0];
	assign open_d    = cmd.open_wr ? open_q + CW'(1) : open_q;

	always_comb begin
		if (pool_slots == '0) begin
			lim = BW'(1);
		end else if (32'(pool_slots) > SLOTS_PER_POOL) begin
			lim = BW'(SLOTS_PER_POOL);
		end else begin
			lim = BW'(pool_slots);
		end
	end

	always_comb begin
		ptr_d = ptr_q;
		if (cmd.capture) begin
			ptr_d = (mode == fspa_pkg::MODE_FREE) ? PW'(free_pool) : PW'(open_q - CW'(1));
		end else if (cmd.walk) begin
			ptr_d = ptr_q - PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= mode;
			req_q   <= request_bytes;
			fpool_q <= free_pool;
			fslot_q <= free_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			open_q  <= CW'(1);
			empty_q <= '1;
			bval_q  <= '0;
		end else begin
			ptr_q  <= ptr_d;
			open_q <= open_d;
			if (cmd.free_wr) begin
				empty_q[ptr_q] <= 1'b0;
			end
			if (cmd.pop_wr) begin
				empty_q[ptr_q] <= link_end;
			end
			if (cmd.bump_wr) begin
				bval_q[ptr_q] <= 1'b1;
			end
			if (cmd.open_wr) begin
				empty_q[open_idx] <= 1'b1;
				bval_q[open_idx]  <= 1'b1;
			end
		end
	end

	assign pool_wr_en   = cmd.free_wr || cmd.bump_wr || cmd.pop_wr || cmd.open_wr;
	assign pool_wr_addr = cmd.open_wr ? open_idx : ptr_q;

	always_comb begin
		pool_wr_data = {bump_cur, head_rd};
		if (cmd.free_wr) begin
			pool_wr_data = {bump_cur, fslot_idx};
		end else if (cmd.bump_wr) begin
			pool_wr_data = {bump_cur + BW'(1), head_rd};
		end else if (cmd.pop_wr) begin
			pool_wr_data = {bump_cur, link_idx};
		end else if (cmd.open_wr) begin
			pool_wr_data = {BW'(1), SW'(0)};
		end
	end

	fspa_ram #(
		.WIDTH  (PWORD_W),
		.DEPTH  (MAX_POOLS),
		.ADDR_W (PW)
	) u_pool_ram (
		.clk     (clk),
		.wr_en   (pool_wr_en),
		.wr_addr (pool_wr_addr),
		.wr_data (pool_wr_data),
		.rd_en   (cmd.capture || cmd.walk),
		.rd_addr (ptr_d),
		.rd_data (pool_rd_data)
	);

	assign link_wr_data = {empty_q[ptr_q], head_rd};
	assign link_wr_addr = LINK_AW'({ptr_q, fslot_idx});
	assign link_rd_addr = LINK_AW'({ptr_q, head_rd});

	fspa_ram #(
		.WIDTH  (LINK_W),
		.DEPTH  (LINK_DEPTH),
		.ADDR_W (LINK_AW)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (cmd.free_wr),
		.wr_addr (link_wr_addr),
		.wr_data (link_wr_data),
		.rd_en   (cmd.link_rd),
		.rd_addr (link_rd_addr),
		.rd_data (link_rd_data)
	);

	assign stat.mode_free = (mode_q == fspa_pkg::MODE_FREE);
	assign stat.oversize  = req_q > slot_bytes;
	assign stat.bad_free  = (32'(fpool_q) >= 32'(open_q)) || (32'(fslot_q) >= 32'(lim));
	assign stat.nonempty  = !empty_q[ptr_q];
	assign stat.bump_ok   = bump_cur < lim;
	assign stat.ptr_zero  = (ptr_q == '0);
	assign stat.can_open  = (32'(open_q) < MAX_POOLS);
	assign stat.out_free  = !out_valid || out_ready;

	always_comb begin
		gp_d = '0;
		gs_d = '0;
		if (cmd.free_wr || cmd.code == fspa_pkg::ST_UNKNOWN) begin
			gp_d = fpool_q;
			gs_d = fslot_q;
		end else if (cmd.pop_wr) begin
			gp_d = fspa_pkg::POOL_FW'(ptr_q);
			gs_d = fspa_pkg::SLOT_FW'(head_rd);
		end else if (cmd.bump_wr) begin
			gp_d = fspa_pkg::POOL_FW'(ptr_q);
			gs_d = fspa_pkg::SLOT_FW'(bump_cur);
		end else if (cmd.open_wr) begin
			gp_d = fspa_pkg::POOL_FW'(open_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			grant_pool <= gp_d;
			grant_slot <= gs_d;
			status     <= cmd.code;
			pools_open <= fspa_pkg::OPEN_FW'(open_d);
		end
	end

endmodule

`default_nettype wire

// ===== sv/fixed_slot_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator
// Fixed-size slot allocator over several pools with per-pool free lists.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  s_*      in         request: tuser = mode, tdata = request_bytes, pool, slot
//  m_*      out        result: tuser = status, tdata = pool, slot, pools_open
//  p*       in/out     configuration registers slot_bytes and pool_slots
//
// A free, a refused request and an allocation from a bump counter are loaded into the
// result from the check state, after a walk over each newer pool passed over.
// A pop from a free list goes on to the link state for the link store read.
// The walk is set by the single read port of the pool state RAM, one pool a cycle.
// Reset is asynchronous and needs no clearing pass; the RAMs are not reset.
// A finished result waits in the output register while the next request enters.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fixed_slot_pool_allocator #(
	parameter int MAX_POOLS      = fspa_pkg::MAX_POOLS_DEF,
	parameter int SLOTS_PER_POOL = fspa_pkg::SLOTS_PER_POOL_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fspa_pkg::APB_AW-1:0]   paddr,
	input  wire logic [fspa_pkg::APB_DW-1:0]   pwdata,
	output      logic [fspa_pkg::APB_DW-1:0]   prdata,
	output      logic                          pready,
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	// request_bytes[16:0], free_pool[19:17], free_slot[29:20], zero pad
	input  wire logic [fspa_pkg::S_DATA_W-1:0] s_tdata,
	// mode[0]
	input  wire logic                          s_tuser,
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	// grant_pool[2:0], grant_slot[12:3], pools_open[16:13], zero pad
	output      logic [fspa_pkg::M_DATA_W-1:0] m_tdata,
	// status[2:0]
	output      logic [fspa_pkg::STATUS_W-1:0] m_tuser
);

	logic [fspa_pkg::SLOT_BYTES_W-1:0] slot_bytes;
	logic [fspa_pkg::POOL_SLOTS_W-1:0] pool_slots;
	fspa_pkg::cmd_t                    cmd;
	fspa_pkg::stat_t                   stat;
	logic [fspa_pkg::POOL_FW-1:0]      grant_pool;
	logic [fspa_pkg::SLOT_FW-1:0]      grant_slot;
	logic [fspa_pkg::OPEN_FW-1:0]      pools_open;

	fspa_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.slot_bytes (slot_bytes),
		.pool_slots (pool_slots)
	);

	fspa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fspa_dp #(
		.MAX_POOLS      (MAX_POOLS),
		.SLOTS_PER_POOL (SLOTS_PER_POOL)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.mode          (s_tuser),
		.request_bytes (s_tdata[16:0]),
		.free_pool     (s_tdata[19:17]),
		.free_slot     (s_tdata[29:20]),
		.slot_bytes    (slot_bytes),
		.pool_slots    (pool_slots),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.grant_pool    (grant_pool),
		.grant_slot    (grant_slot),
		.status        (m_tuser),
		.pools_open    (pools_open)
	);

	assign m_tdata = {7'd0, pools_open, grant_slot, grant_pool};

	`ASSERT_NEXT(a_one_request_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready, "request accepted while another is in flight")
	`ASSERT_NOW(a_load_into_free_slot, clk, arst_n, cmd.load_out, !m_tvalid || m_tready, "result register overwritten before transfer")
	`ASSERT_NEXT(a_load_shows_result, clk, arst_n, cmd.load_out, m_tvalid, "loaded result not presented")
	`ASSERT_NOW(a_single_commit, clk, arst_n, 1'b1, $onehot0({cmd.free_wr, cmd.bump_wr, cmd.pop_wr, cmd.open_wr}), "more than one pool state commit in a cycle")

endmodule

`default_nettype wire
